// ----- hdl/csrt_pkg.sv -----
// Shared types, constants and codes of the CSR transpose counting-sort block.
package csrt_pkg;

  localparam int MAX_CELLS       = 1024;
  localparam int MAX_CONNECTIONS = 4096;

  localparam int CELL_AW = $clog2(MAX_CELLS);
  localparam int CONN_AW = $clog2(MAX_CONNECTIONS);
  localparam int CNT_W   = CONN_AW + 1;
  localparam int SCAN_W  = CELL_AW + 1;
  localparam int CFG_W   = 11;
  localparam int WELL_W  = 8;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 3;
  localparam int IDX_W   = 13;

  localparam logic [CFG_W-1:0] CELL_COUNT_RESET = CFG_W'(MAX_CELLS);

  localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
  localparam logic [OP_W-1:0] OP_FINISH   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ_PTR = 2'd2;
  localparam logic [OP_W-1:0] OP_READ_ENT = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_CELL_RANGE = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL       = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX  = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_DONE   = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [CELL_AW-1:0] cell_req;
    logic [WELL_W-1:0]  well;
    logic [IDX_W-1:0]   index;
  } req_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [CNT_W-1:0]   position;
    logic [WELL_W-1:0]  entry_well;
    logic [CONN_AW-1:0] entry_connection;
  } res_item_t;

  typedef struct packed {
    logic [CELL_AW-1:0] cell_id;
    logic [WELL_W-1:0]  well;
  } conn_word_t;

  typedef struct packed {
    logic [WELL_W-1:0]  well;
    logic [CONN_AW-1:0] conn;
  } map_word_t;

  typedef struct packed {
    logic               we;
    logic [CELL_AW-1:0] waddr;
    logic [CNT_W-1:0]   wdata;
    logic               re;
    logic [CELL_AW-1:0] raddr;
  } cnt_port_t;

  typedef struct packed {
    logic               we;
    logic [CONN_AW-1:0] waddr;
    conn_word_t         wdata;
    logic               re;
    logic [CONN_AW-1:0] raddr;
  } conn_port_t;

  typedef struct packed {
    logic               we;
    logic [CONN_AW-1:0] waddr;
    map_word_t          wdata;
    logic               re;
    logic [CONN_AW-1:0] raddr;
  } map_port_t;

endpackage

// ----- hdl/csrt_ram.sv -----
// Simple dual-port synchronous RAM with a registered read port.
module csrt_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 13,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/csrt_ctrl.sv -----
// Sequencer: request decode, counter clear, prefix sum, scatter and result register.
module csrt_ctrl
  import csrt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_item_t          req_data,
  output logic               res_valid,
  input  logic               res_stall,
  output res_item_t          res_data,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_data,
  output cnt_port_t          cnt_port,
  input  logic [CNT_W-1:0]   cnt_rdata,
  output conn_port_t         conn_port,
  input  conn_word_t         conn_rdata,
  output map_port_t          map_port,
  input  map_word_t          map_rdata
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EXEC     = 4'd1;
  localparam logic [3:0] S_CLEAR    = 4'd2;
  localparam logic [3:0] S_ADD_WR   = 4'd3;
  localparam logic [3:0] S_PREFIX   = 4'd4;
  localparam logic [3:0] S_SCAT_RD  = 4'd5;
  localparam logic [3:0] S_SCAT_CNT = 4'd6;
  localparam logic [3:0] S_SCAT_WR  = 4'd7;
  localparam logic [3:0] S_READ_PTR = 4'd8;
  localparam logic [3:0] S_READ_ENT = 4'd9;
  localparam logic [3:0] S_RESULT   = 4'd10;

  logic [3:0]         state;
  logic [CFG_W-1:0]   cell_count;
  logic               finished;
  logic               pending;
  logic [CNT_W-1:0]   total;
  logic [SCAN_W-1:0]  scan;
  logic [CNT_W-1:0]   acc;
  logic [CNT_W-1:0]   k;
  req_item_t          req;
  res_item_t          res;

  logic [CFG_W-1:0]   rows;
  logic               add_ok;
  logic               ptr_ok;
  logic               ent_ok;
  logic               full;

  assign rows = (cell_count > CELL_COUNT_RESET) ? CELL_COUNT_RESET : cell_count;
  assign full = total[CONN_AW];
  assign add_ok = ({1'b0, req.cell_req} < rows) && !full;
  assign ptr_ok = (req.index <= {{(IDX_W - CFG_W){1'b0}}, rows}) && (req.index != '0);
  assign ent_ok = req.index < total;

  assign req_stall = (state != S_IDLE);

  // memory port drive
  always_comb begin
    cnt_port  = '0;
    conn_port = '0;
    map_port  = '0;
    unique case (state)
      S_CLEAR: begin
        cnt_port.we    = 1'b1;
        cnt_port.waddr = scan[CELL_AW-1:0];
        cnt_port.wdata = '0;
      end
      S_EXEC: begin
        unique case (req.operation)
          OP_ADD: begin
            if (!finished && add_ok) begin
              cnt_port.re     = 1'b1;
              cnt_port.raddr  = req.cell_req;
              conn_port.we    = 1'b1;
              conn_port.waddr = total[CONN_AW-1:0];
              conn_port.wdata = '{cell_id: req.cell_req, well: req.well};
            end
          end
          OP_READ_PTR: begin
            if (finished && ptr_ok) begin
              cnt_port.re    = 1'b1;
              cnt_port.raddr = CELL_AW'(req.index - IDX_W'(1));
            end
          end
          OP_READ_ENT: begin
            if (finished && ent_ok) begin
              map_port.re    = 1'b1;
              map_port.raddr = req.index[CONN_AW-1:0];
            end
          end
          default: begin
          end
        endcase
      end
      S_ADD_WR: begin
        cnt_port.we    = 1'b1;
        cnt_port.waddr = req.cell_req;
        cnt_port.wdata = cnt_rdata + CNT_W'(1);
      end
      S_PREFIX: begin
        // read row scan while writing the running sum back to row scan-1
        cnt_port.re    = !scan[CELL_AW];
        cnt_port.raddr = scan[CELL_AW-1:0];
        cnt_port.we    = (scan != '0);
        cnt_port.waddr = CELL_AW'(scan - SCAN_W'(1));
        cnt_port.wdata = acc;
      end
      S_SCAT_RD: begin
        conn_port.re    = (k != total);
        conn_port.raddr = k[CONN_AW-1:0];
      end
      S_SCAT_CNT: begin
        cnt_port.re    = 1'b1;
        cnt_port.raddr = conn_rdata.cell_id;
      end
      S_SCAT_WR: begin
        map_port.we    = 1'b1;
        map_port.waddr = cnt_rdata[CONN_AW-1:0];
        map_port.wdata = '{well: conn_rdata.well, conn: k[CONN_AW-1:0]};
        cnt_port.we    = 1'b1;
        cnt_port.waddr = conn_rdata.cell_id;
        cnt_port.wdata = cnt_rdata + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cell_count <= CELL_COUNT_RESET;
      finished   <= 1'b0;
      pending    <= 1'b0;
      total      <= '0;
      scan       <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cell_count <= cfg_data;
      end
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req   <= req_data;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res <= '0;
          unique case (req.operation)
            OP_ADD: begin
              if (finished) begin
                // new batch: clear counters, then run this add again
                finished <= 1'b0;
                total    <= '0;
                pending  <= 1'b1;
                scan     <= '0;
                state    <= S_CLEAR;
              end else if ({1'b0, req.cell_req} >= rows) begin
                res.status <= ST_CELL_RANGE;
                state      <= S_RESULT;
              end else if (full) begin
                res.status <= ST_FULL;
                state      <= S_RESULT;
              end else begin
                state <= S_ADD_WR;
              end
            end
            OP_FINISH: begin
              if (finished) begin
                res.position <= total;
                state        <= S_RESULT;
              end else begin
                scan  <= '0;
                acc   <= '0;
                state <= S_PREFIX;
              end
            end
            OP_READ_PTR: begin
              if (!finished) begin
                res.status <= ST_NOT_DONE;
                state      <= S_RESULT;
              end else if (req.index > {{(IDX_W - CFG_W){1'b0}}, rows}) begin
                res.status <= ST_BAD_INDEX;
                state      <= S_RESULT;
              end else if (req.index == '0) begin
                state <= S_RESULT;
              end else begin
                state <= S_READ_PTR;
              end
            end
            OP_READ_ENT: begin
              if (!finished) begin
                res.status <= ST_NOT_DONE;
                state      <= S_RESULT;
              end else if (!ent_ok) begin
                res.status <= ST_BAD_INDEX;
                state      <= S_RESULT;
              end else begin
                state <= S_READ_ENT;
              end
            end
            default: begin
            end
          endcase
        end
        S_CLEAR: begin
          scan <= scan + SCAN_W'(1);
          if (scan[CELL_AW-1:0] == '1) begin
            scan    <= '0;
            pending <= 1'b0;
            state   <= pending ? S_EXEC : S_IDLE;
          end
        end
        S_ADD_WR: begin
          total <= total + CNT_W'(1);
          state <= S_RESULT;
        end
        S_PREFIX: begin
          if (scan != '0) begin
            acc <= acc + cnt_rdata;
          end
          scan <= scan + SCAN_W'(1);
          if (scan == SCAN_W'(MAX_CELLS)) begin
            k     <= '0;
            state <= S_SCAT_RD;
          end
        end
        S_SCAT_RD: begin
          if (k == total) begin
            finished     <= 1'b1;
            res.position <= total;
            state        <= S_RESULT;
          end else begin
            state <= S_SCAT_CNT;
          end
        end
        S_SCAT_CNT: begin
          state <= S_SCAT_WR;
        end
        S_SCAT_WR: begin
          k     <= k + CNT_W'(1);
          state <= S_SCAT_RD;
        end
        S_READ_PTR: begin
          res.position <= cnt_rdata;
          state        <= S_RESULT;
        end
        S_READ_ENT: begin
          res.entry_well       <= map_rdata.well;
          res.entry_connection <= map_rdata.conn;
          state                <= S_RESULT;
        end
        S_RESULT: begin
          // hold until the output register is free
          if (!res_valid || !res_stall) begin
            res_data  <= res;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/csr_transpose_counting_sort_core.sv -----
// Top level of the CSR transpose counting-sort block: controller and its three memories.
//
// Requests enter on req_valid/req_stall/req_data and results leave on
// res_valid/res_stall/res_data; a transfer happens when valid is high and
// stall is low. Every request gives exactly one result, in request order.
// The user writes cell_count through cfg_we/cfg_data only while the block is
// idle; the block itself does not enforce this. One request is worked on at
// a time; the controller sequences the single counter memory. A finish that
// builds the map makes one prefix pass over 1024 counter rows, then scatters
// each connection in turn; the first add after a finish clears the counters
// before it is handled. A refused request, a repeated finish and a row 0
// read go from decode straight to the result register. A new request is
// taken again from the cycle after the result is loaded. After reset
// req_stall stays high while the counter memory is cleared; configuration
// writes are taken during that time. A result waiting under res_stall is
// held in the output register; the block keeps accepting and working on the
// next request, whose result then waits until the output register frees up.
module csr_transpose_counting_sort_core
  import csrt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_item_t        req_data,
  output logic             res_valid,
  input  logic             res_stall,
  output res_item_t        res_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);

  cnt_port_t          cnt_port;
  logic [CNT_W-1:0]   cnt_rdata;
  conn_port_t         conn_port;
  conn_word_t         conn_rdata;
  map_port_t          map_port;
  map_word_t          map_rdata;

  csrt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_data   (req_data),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .cnt_port   (cnt_port),
    .cnt_rdata  (cnt_rdata),
    .conn_port  (conn_port),
    .conn_rdata (conn_rdata),
    .map_port   (map_port),
    .map_rdata  (map_rdata)
  );

  // per-cell counters, later row pointers
  csrt_ram #(.DEPTH(MAX_CELLS), .WIDTH(CNT_W)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_port.we),
    .waddr (cnt_port.waddr),
    .wdata (cnt_port.wdata),
    .re    (cnt_port.re),
    .raddr (cnt_port.raddr),
    .rdata (cnt_rdata)
  );

  // connections in arrival order
  csrt_ram #(.DEPTH(MAX_CONNECTIONS), .WIDTH($bits(conn_word_t))) u_conn_ram (
    .clk   (clk),
    .we    (conn_port.we),
    .waddr (conn_port.waddr),
    .wdata (conn_port.wdata),
    .re    (conn_port.re),
    .raddr (conn_port.raddr),
    .rdata (conn_rdata)
  );

  // sorted cell-to-well map
  csrt_ram #(.DEPTH(MAX_CONNECTIONS), .WIDTH($bits(map_word_t))) u_map_ram (
    .clk   (clk),
    .we    (map_port.we),
    .waddr (map_port.waddr),
    .wdata (map_port.wdata),
    .re    (map_port.re),
    .raddr (map_port.raddr),
    .rdata (map_rdata)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while another is in progress");

  a_cnt_no_collision: assert property (@(posedge clk) disable iff (rst)
    cnt_port.we && cnt_port.re |-> cnt_port.waddr != cnt_port.raddr)
    else $error("counter read and write hit the same row");

  a_refused_entry_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status != ST_OK |->
      res_data.entry_well == '0 && res_data.entry_connection == '0)
    else $error("refused request carries entry data");

  a_map_write_in_scatter: assert property (@(posedge clk) disable iff (rst)
    map_port.we |-> cnt_port.we && !conn_port.we)
    else $error("map written outside the scatter step");

endmodule

// ----- sim/csr_transpose_counting_sort_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the CSR transpose counting-sort core.
module csr_transpose_counting_sort_core_test;
  import csrt_pkg::*;

  localparam int CYCLE_LIMIT = 5_000_000;

  // Predicts the cell map and flags any result that differs from it.
  class csr_map_scoreboard;
    bit [CELL_AW-1:0] conn_cell [MAX_CONNECTIONS];
    bit [WELL_W-1:0]  conn_well [MAX_CONNECTIONS];
    bit [CNT_W-1:0]   row_start [MAX_CELLS+1];
    bit [WELL_W-1:0]  map_well [MAX_CONNECTIONS];
    bit [CONN_AW-1:0] map_conn [MAX_CONNECTIONS];
    bit [CNT_W-1:0]   conn_total;
    bit               map_built;
    int unsigned      rows;
    int unsigned      errors;
    res_item_t        awaited[$];

    function new();
      rows = MAX_CELLS;
    endfunction

    function void set_cell_count(int unsigned v);
      rows = (v > MAX_CELLS) ? MAX_CELLS : v;
    endfunction

    // Turn per-cell counts into row pointers, then scatter in arrival order.
    function void place_connections();
      bit [CNT_W-1:0] acc;
      bit [CNT_W-1:0] n;
      bit [CNT_W-1:0] slot;
      int c;
      acc = '0;
      for (int r = 1; r <= MAX_CELLS; r++) begin
        n = row_start[r];
        row_start[r] = acc;
        acc += n;
      end
      row_start[0] = '0;
      for (int k = 0; k < conn_total; k++) begin
        c = conn_cell[k];
        slot = row_start[c+1];
        map_well[slot] = conn_well[k];
        map_conn[slot] = CONN_AW'(k);
        row_start[c+1] = slot + 1'b1;
      end
    endfunction

    function void note_request(req_item_t rq);
      res_item_t r;
      int c;
      r = '0;
      c = rq.cell_req;
      case (rq.operation)
        OP_ADD: begin
          // a new batch starts: drop the old counts even if the add is refused
          if (map_built) begin
            foreach (row_start[i]) row_start[i] = '0;
            conn_total = '0;
            map_built = 1'b0;
          end
          if (c >= rows) begin
            r.status = ST_CELL_RANGE;
          end else if (conn_total >= MAX_CONNECTIONS) begin
            r.status = ST_FULL;
          end else begin
            conn_cell[conn_total] = rq.cell_req;
            conn_well[conn_total] = rq.well;
            row_start[c+1] += 1'b1;
            conn_total += 1'b1;
          end
        end
        OP_FINISH: begin
          if (!map_built) begin
            place_connections();
            map_built = 1'b1;
          end
          r.position = conn_total;
        end
        default: begin
          if (!map_built) begin
            r.status = ST_NOT_DONE;
          end else if (rq.operation == OP_READ_PTR) begin
            if (rq.index > rows) r.status = ST_BAD_INDEX;
            else r.position = row_start[rq.index];
          end else begin
            if (rq.index >= conn_total) begin
              r.status = ST_BAD_INDEX;
            end else begin
              r.entry_well = map_well[rq.index];
              r.entry_connection = map_conn[rq.index];
            end
          end
        end
      endcase
      awaited.push_back(r);
    endfunction

    function void check_result(res_item_t got);
      res_item_t want;
      if (awaited.size() == 0) begin
        $error("result %h arrived with no request outstanding", got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.position !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, got.position);
        errors++;
      end
      if (got.entry_well !== want.entry_well) begin
        $error("entry_well: expected %0d, got %0d", want.entry_well, got.entry_well);
        errors++;
      end
      if (got.entry_connection !== want.entry_connection) begin
        $error("entry_connection: expected %0d, got %0d",
               want.entry_connection, got.entry_connection);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  req_item_t        req_data = '0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  res_item_t        res_data;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = CELL_COUNT_RESET;

  csr_map_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int unsigned sent = 0;
  int unsigned rows = MAX_CELLS;
  int gap_pct = 0;
  bit quiet = 1'b0;

  csr_transpose_counting_sort_core uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(req_data);
      if (res_valid && !res_stall) sb.check_result(res_data);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver stalls in bursts, with long clear stretches between them.
  initial begin
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (quiet || $urandom_range(0, 2) != 0) begin
        res_stall <= 1'b0;
        repeat ($urandom_range(1, 150)) @(posedge clk);
      end else begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  function automatic req_item_t make_req(logic [OP_W-1:0] op, int cell_ix, int well_ix,
                                         int idx);
    req_item_t r;
    r.operation = op;
    r.cell_req  = CELL_AW'(cell_ix);
    r.well      = WELL_W'(well_ix);
    r.index     = IDX_W'(idx);
    return r;
  endfunction

  function automatic int pick_cell();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, rows - 1);
    return $urandom_range(0, 1023);
  endfunction

  function automatic int pick_row();
    if ($urandom_range(0, 9) != 0) return $urandom_range(0, rows);
    return $urandom_range(0, 8191);
  endfunction

  function automatic int pick_entry();
    if (sb.conn_total > 0 && $urandom_range(0, 9) != 0)
      return $urandom_range(0, sb.conn_total - 1);
    return $urandom_range(0, 8191);
  endfunction

  // Hold the request until the block takes it; keep valid up for the next one.
  task automatic send_req(input req_item_t item);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
  endtask

  task automatic add_conn(input int cell_ix, input int well_ix);
    send_req(make_req(OP_ADD, cell_ix, well_ix, $urandom_range(0, 8191)));
  endtask

  task automatic finish_batch();
    send_req(make_req(OP_FINISH, $urandom_range(0, 1023), $urandom_range(0, 255),
                      $urandom_range(0, 8191)));
  endtask

  task automatic read_row(input int idx);
    send_req(make_req(OP_READ_PTR, $urandom_range(0, 1023), $urandom_range(0, 255), idx));
  endtask

  task automatic read_entry(input int idx);
    send_req(make_req(OP_READ_ENT, $urandom_range(0, 1023), $urandom_range(0, 255), idx));
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cell_count(input int v);
    cfg_we   <= 1'b1;
    cfg_data <= CFG_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    rows = (v > MAX_CELLS) ? MAX_CELLS : v;
    sb.set_cell_count(v);
  endtask

  task automatic random_segment();
    int pick;
    int n;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 100) : $urandom_range(0, 12);
      repeat (n) add_conn(pick_cell(), $urandom_range(0, 255));
      finish_batch();
      repeat ($urandom_range(1, 10)) begin
        if ($urandom_range(0, 1) == 0) read_row(pick_row());
        else read_entry(pick_entry());
      end
      if ($urandom_range(0, 3) == 0) finish_batch();
    end else if (pick < 9) begin
      repeat ($urandom_range(1, 6))
        send_req(make_req(OP_W'($urandom_range(0, 3)), $urandom_range(0, 1023),
                          $urandom_range(0, 255), $urandom_range(0, 8191)));
    end else begin
      // broken sequence: reads land before the batch is finished
      repeat ($urandom_range(1, 4)) add_conn(pick_cell(), $urandom_range(0, 255));
      read_row(pick_row());
      read_entry(pick_entry());
      finish_batch();
    end
  endtask

  initial begin
    int cfg_plan [11];
    int unsigned phase_start;
    int unsigned wait_cycles;

    cfg_plan = '{1024, 1, 2, 1023, 512, 3, 1024, 64, 0, 17, 1024};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // the block takes the register while it clears its counters
    write_cell_count(MAX_CELLS);

    gap_pct = 20;
    read_row(0);
    read_entry(0);
    finish_batch();
    finish_batch();
    read_row(1024);
    read_row(1025);
    read_entry(0);
    add_conn(0, 0);
    add_conn(1023, 255);
    add_conn(5, 8'hAA);
    add_conn(0, 8'h55);
    add_conn(1023, 1);
    finish_batch();
    read_row(0);
    read_row(1);
    read_row(1023);
    read_row(1024);
    for (int i = 0; i < 5; i++) read_entry(i);
    read_entry(5);
    read_entry(8191);

    // fill the connection store to the last slot, then overflow it
    drain();
    gap_pct = 10;
    repeat (MAX_CONNECTIONS) add_conn($urandom_range(0, 1023), $urandom_range(0, 255));
    add_conn($urandom_range(0, 1023), $urandom_range(0, 255));
    add_conn(1023, 255);
    finish_batch();
    read_row(0);
    read_row(1024);
    read_entry(0);
    read_entry(MAX_CONNECTIONS - 1);
    read_entry(MAX_CONNECTIONS);

    for (int p = 0; p < 11; p++) begin
      drain();
      write_cell_count(cfg_plan[p]);
      if (p == 10) quiet = 1'b1;
      gap_pct = quiet ? 0 : 15 * $urandom_range(0, 2);
      phase_start = sent;
      while (sent - phase_start < 65) random_segment();
      // leave a batch open so the next count applies mid-batch
      repeat ($urandom_range(1, 6)) add_conn(pick_cell(), $urandom_range(0, 255));
    end
    finish_batch();
    read_row(rows);
    read_entry(0);

    req_valid <= 1'b0;
    wait_cycles = 0;
    @(posedge clk);
    while (sb.awaited.size() != 0 && wait_cycles < 50_000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (sb.awaited.size() != 0) begin
      $error("%0d expected results never arrived", sb.awaited.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
